// ----- rtl/gcb_pkg.sv -----
// shared types, constants and codes of the growable character buffer
package gcb_pkg;

  localparam int unsigned MAX_CAP     = 4095;
  localparam int unsigned DEFAULT_CAP = 200;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned DEFAULT_INC = 15;
  localparam int unsigned PERCENT     = 100;

  typedef enum logic [3:0] {
    CMD_OPEN       = 4'd0,
    CMD_ADD        = 4'd1,
    CMD_GET        = 4'd2,
    CMD_MARK       = 4'd3,
    CMD_RETRACT    = 4'd4,
    CMD_RESET_MARK = 4'd5,
    CMD_REWIND     = 4'd6,
    CMD_CLEAR      = 4'd7,
    CMD_COMPACT    = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_FIXED = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_MULT  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_INC  = 2'd1,
    CFG_CAP  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RECIP,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic mul1_en;
    logic mul2_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_mult;
    logic get_read;
  } dp_status_t;

endpackage

// ----- rtl/gcb_ram.sv -----
// generic single port ram with registered read
module gcb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gcb_ctrl.sv -----
// sequencing state machine and output valid of the character buffer
module gcb_ctrl import gcb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_in = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status_i.need_mult) begin
          ctrl_o.mul1_en = 1'b1;
          state_d        = ST_RECIP;
        end else begin
          ctrl_o.rd_en = status_i.get_read;
          state_d      = ST_COMMIT;
        end
      end
      ST_RECIP: begin
        ctrl_o.mul2_en = 1'b1;
        state_d        = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the previous result has left the output register
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.commit = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/gcb_dp.sv -----
// datapath: offsets, capacity, growth arithmetic, byte store and result register
module gcb_dp import gcb_pkg::*; #(
  parameter int unsigned MaxCap     = MAX_CAP,
  parameter int unsigned DefaultCap = DEFAULT_CAP
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         ctrl_i,
  output dp_status_t        status_o,
  input  logic [3:0]        cmd_i,
  input  logic [7:0]        symbol_i,
  input  logic [CNT_W-1:0]  mark_position_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [11:0]       cfg_data_i,
  output logic              res_status_o,
  output logic [7:0]        read_byte_o,
  output logic              end_of_buffer_o,
  output logic              grew_o,
  output logic [CNT_W-1:0]  fill_count_o,
  output logic [CNT_W-1:0]  current_capacity_o,
  output logic [CNT_W-1:0]  read_position_o
);

  localparam int unsigned CapBits   = $clog2(MaxCap + 1);
  localparam int unsigned CapW      = (CNT_W > CapBits) ? CNT_W : CapBits;
  localparam int unsigned ProdW     = CapW + 7;
  localparam int unsigned RecipK    = ProdW + 7;
  localparam int unsigned MW        = RecipK - 6;
  localparam int unsigned DefCapSat = (DefaultCap > MaxCap) ? MaxCap : DefaultCap;
  localparam logic [MW-1:0]   RecipM  = MW'(((64'd1 << RecipK) + 64'd99) / 64'd100);
  localparam logic [CapW-1:0] MaxCapC = CapW'(MaxCap);
  localparam logic [CapW-1:0] DefCapC = CapW'(DefCapSat);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(STORE_DEPTH);

  // request captured at accept
  logic [3:0]       cmd_q;
  logic [7:0]       sym_q;
  logic [CNT_W-1:0] pos_q;

  // configuration
  logic [1:0]  cfg_mode_q;
  logic [7:0]  cfg_inc_q;
  logic [11:0] cfg_cap_q;

  // buffer state
  logic [CNT_W-1:0] fill_q, fill_d, read_q, read_d, mark_q, mark_d;
  logic [CapW-1:0]  cap_q, cap_d;
  logic [1:0]       mode_q, mode_d;
  logic [7:0]       inc_q, inc_d;
  logic             grew_q, grew_d, eob_q, eob_d, opened_q, opened_d;

  // growth arithmetic
  logic [CapW+7:0]     mul1_full;
  logic [ProdW-1:0]    prod1_q;
  logic [ProdW+MW-1:0] mul2_full;
  logic [ProdW+MW-1:0] prod2_q;
  logic [CapW-1:0]     delta;
  logic [CapW:0]       add_sum;
  logic [CapW-1:0]     add_cap;

  // open checks
  logic [CapW-1:0] open_cap;
  logic [7:0]      open_inc;
  logic            open_ok;

  logic            ok;
  logic [7:0]      rbyte;
  logic            ram_we;
  logic [7:0]      ram_rdata;
  logic            fill_lt_cap, store_room;

  // result register
  logic             res_status_q;
  logic [7:0]       res_byte_q;
  logic             res_eob_q, res_grew_q;
  logic [CNT_W-1:0] res_fill_q, res_cap_q, res_read_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      cmd_q <= cmd_i;
      sym_q <= symbol_i;
      pos_q <= mark_position_i;
    end
    if (ctrl_i.mul1_en) begin
      prod1_q <= mul1_full[ProdW-1:0];
    end
    if (ctrl_i.mul2_en) begin
      prod2_q <= mul2_full;
    end
    if (ctrl_i.commit) begin
      res_status_q <= ~ok;
      res_byte_q   <= rbyte;
      res_eob_q    <= eob_d;
      res_grew_q   <= grew_d;
      res_fill_q   <= fill_d;
      res_cap_q    <= cap_d[CNT_W-1:0];
      res_read_q   <= read_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_mode_q <= '0;
      cfg_inc_q  <= '0;
      cfg_cap_q  <= '0;
      fill_q     <= '0;
      read_q     <= '0;
      mark_q     <= '0;
      cap_q      <= '0;
      mode_q     <= '0;
      inc_q      <= '0;
      grew_q     <= 1'b0;
      eob_q      <= 1'b0;
      opened_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE: cfg_mode_q <= cfg_data_i[1:0];
          CFG_INC:  cfg_inc_q  <= cfg_data_i[7:0];
          CFG_CAP:  cfg_cap_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (ctrl_i.commit) begin
        fill_q   <= fill_d;
        read_q   <= read_d;
        mark_q   <= mark_d;
        cap_q    <= cap_d;
        mode_q   <= mode_d;
        inc_q    <= inc_d;
        grew_q   <= grew_d;
        eob_q    <= eob_d;
        opened_q <= opened_d;
      end
    end
  end

  assign fill_lt_cap = CapW'(fill_q) < cap_q;
  assign store_room  = fill_q < DepthC;

  assign status_o.need_mult = opened_q && (cmd_q == CMD_ADD) && store_room && !fill_lt_cap &&
                              (mode_q == MODE_MULT) && (cap_q < MaxCapC);
  assign status_o.get_read  = opened_q && (cmd_q == CMD_GET) && (read_q < fill_q);

  // floor(free * inc / 100) as a product and a reciprocal multiply
  assign mul1_full = (CapW+8)'(MaxCapC - cap_q) * (CapW+8)'(inc_q);
  assign mul2_full = (ProdW+MW)'(prod1_q) * (ProdW+MW)'(RecipM);
  assign delta     = CapW'(prod2_q >> RecipK);

  assign add_sum = (CapW+1)'(cap_q) + (CapW+1)'(inc_q);
  assign add_cap = (add_sum > (CapW+1)'(MaxCapC)) ? MaxCapC : add_sum[CapW-1:0];

  always_comb begin
    open_cap = (cfg_cap_q == '0) ? DefCapC : CapW'(cfg_cap_q);
    open_inc = (cfg_cap_q == '0) ? 8'(DEFAULT_INC) : cfg_inc_q;
    if (cfg_mode_q == MODE_FIXED) begin
      open_inc = '0;
    end
    open_ok = (cfg_mode_q <= MODE_MULT) && (CapW'(cfg_cap_q) <= MaxCapC) &&
              !((cfg_mode_q == MODE_MULT) && (open_inc > 8'(PERCENT)));
  end

  always_comb begin
    fill_d   = fill_q;
    read_d   = read_q;
    mark_d   = mark_q;
    cap_d    = cap_q;
    mode_d   = mode_q;
    inc_d    = inc_q;
    grew_d   = grew_q;
    eob_d    = eob_q;
    opened_d = opened_q;
    ok       = 1'b0;
    rbyte    = '0;
    ram_we   = 1'b0;
    if (cmd_q == CMD_OPEN) begin
      if (open_ok) begin
        ok       = 1'b1;
        mode_d   = cfg_mode_q;
        inc_d    = open_inc;
        cap_d    = open_cap;
        fill_d   = '0;
        read_d   = '0;
        mark_d   = '0;
        grew_d   = 1'b0;
        eob_d    = 1'b0;
        opened_d = 1'b1;
      end
    end else if (opened_q) begin
      case (cmd_q)
        CMD_ADD: begin
          grew_d = 1'b0;
          if (store_room) begin
            if (fill_lt_cap) begin
              ok = 1'b1;
            end else if (cap_q < MaxCapC) begin
              if ((mode_q == MODE_ADD) && (inc_q != '0)) begin
                ok     = 1'b1;
                grew_d = 1'b1;
                cap_d  = add_cap;
              end else if (mode_q == MODE_MULT) begin
                ok     = 1'b1;
                grew_d = 1'b1;
                cap_d  = (delta == '0) ? MaxCapC : cap_q + delta;
              end
            end
          end
          if (ok) begin
            ram_we = 1'b1;
            fill_d = fill_q + 1'b1;
          end
        end
        CMD_GET: begin
          ok = 1'b1;
          if (read_q < fill_q) begin
            eob_d  = 1'b0;
            rbyte  = ram_rdata;
            read_d = read_q + 1'b1;
          end else begin
            eob_d = 1'b1;
          end
        end
        CMD_MARK: begin
          if (pos_q <= fill_q) begin
            ok     = 1'b1;
            mark_d = pos_q;
          end
        end
        CMD_RETRACT: begin
          if (read_q != '0) begin
            ok     = 1'b1;
            read_d = read_q - 1'b1;
          end
        end
        CMD_RESET_MARK: begin
          ok     = 1'b1;
          read_d = mark_q;
        end
        CMD_REWIND: begin
          ok     = 1'b1;
          read_d = '0;
          mark_d = '0;
        end
        CMD_CLEAR: begin
          ok     = 1'b1;
          fill_d = '0;
          read_d = '0;
          mark_d = '0;
          grew_d = 1'b0;
        end
        CMD_COMPACT: begin
          if (store_room) begin
            ok     = 1'b1;
            ram_we = 1'b1;
            cap_d  = CapW'(fill_q) + 1'b1;
            fill_d = fill_q + 1'b1;
            grew_d = 1'b1;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  gcb_ram #(
    .Width (8),
    .Depth (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we && ctrl_i.commit),
    .re_i    (ctrl_i.rd_en),
    .addr_i  (ctrl_i.commit ? fill_q[ADDR_W-1:0] : read_q[ADDR_W-1:0]),
    .wdata_i (sym_q),
    .rdata_o (ram_rdata)
  );

  assign res_status_o       = res_status_q;
  assign read_byte_o        = res_byte_q;
  assign end_of_buffer_o    = res_eob_q;
  assign grew_o             = res_grew_q;
  assign fill_count_o       = res_fill_q;
  assign current_capacity_o = res_cap_q;
  assign read_position_o    = res_read_q;

endmodule

// ----- rtl/growable_char_buffer.sv -----
// top level of the growable character buffer
//
//  channel  | valid / ready           | payload
//  ---------+-------------------------+----------------------------------------------
//  in       | in_valid_i / in_ready_o | cmd_i, symbol_i, mark_position_i
//  out      | out_valid_o/out_ready_i | status_o, read_byte_o, end_of_buffer_o, grew_o,
//           |                         | fill_count_o, current_capacity_o, read_position_o
//  cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  a request steps through accept, decode (store read for get) and commit
//  multiplicative growth adds the recip state for the second pipelined multiply
//  one request is in work at a time; the result register frees the input side
//  a result waiting on out_ready_i holds the next request in its commit cycle
//  reset clears the offsets, capacity and flags; the byte store is not cleared
module growable_char_buffer import gcb_pkg::*; #(
  parameter int unsigned MaxCap     = MAX_CAP,
  parameter int unsigned DefaultCap = DEFAULT_CAP
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [3:0]       cmd_i,
  input  logic [7:0]       symbol_i,
  input  logic [CNT_W-1:0] mark_position_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             status_o,
  output logic [7:0]       read_byte_o,
  output logic             end_of_buffer_o,
  output logic             grew_o,
  output logic [CNT_W-1:0] fill_count_o,
  output logic [CNT_W-1:0] current_capacity_o,
  output logic [CNT_W-1:0] read_position_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [11:0]      cfg_data_i
);

  ctrl_cmd_t  ctrl;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  gcb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .ctrl_o      (ctrl)
  );

  gcb_dp #(
    .MaxCap     (MaxCap),
    .DefaultCap (DefaultCap)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctrl_i             (ctrl),
    .status_o           (dp_status),
    .cmd_i              (cmd_i),
    .symbol_i           (symbol_i),
    .mark_position_i    (mark_position_i),
    .cfg_we_i           (cfg_valid_i && cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .res_status_o       (status_o),
    .read_byte_o        (read_byte_o),
    .end_of_buffer_o    (end_of_buffer_o),
    .grew_o             (grew_o),
    .fill_count_o       (fill_count_o),
    .current_capacity_o (current_capacity_o),
    .read_position_o    (read_position_o)
  );

endmodule

// ----- rtl/gcb_checker.sv -----
// port level checks of the growable character buffer and their binding
module gcb_checker import gcb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic [3:0]       cmd_i,
  input logic [7:0]       symbol_i,
  input logic [CNT_W-1:0] mark_position_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic             status_o,
  input logic [7:0]       read_byte_o,
  input logic             end_of_buffer_o,
  input logic             grew_o,
  input logic [CNT_W-1:0] fill_count_o,
  input logic [CNT_W-1:0] current_capacity_o,
  input logic [CNT_W-1:0] read_position_o
);

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fill_count_o) &&
    $stable(read_position_o) && $stable(status_o) && $stable(read_byte_o) &&
    $stable(end_of_buffer_o) && $stable(grew_o) && $stable(current_capacity_o))
    else $error("result changed while stalled");

  // a waiting request keeps its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(cmd_i) && $stable(symbol_i) &&
    $stable(mark_position_i))
    else $error("request changed while waiting");

  // the read offset never passes the fill count
  a_read_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> read_position_o <= fill_count_o)
    else $error("read position beyond fill count");

  // end of buffer always comes with a zero byte
  a_eob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_buffer_o |-> read_byte_o == 8'd0)
    else $error("byte returned at end of buffer");

  // only one request in work: no accept in the cycle after an accept
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in work");

endmodule

bind growable_char_buffer gcb_checker u_gcb_checker (.*);
